/* design/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is applied.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dhse_pkg.sv */
// Shared types and constants of the DEFLATE Huffman symbol encoder.
package dhse_pkg;

  localparam int LITLEN_SYMBOLS_DEF = 286;
  localparam int DIST_SYMBOLS_DEF   = 30;
  localparam int MAX_CODE_BITS      = 15;
  localparam int LEN_W              = 4;
  localparam int ENTRY_W            = MAX_CODE_BITS + LEN_W;
  localparam int LIT_SYM_W          = 9;
  localparam int DIST_SYM_W         = 5;
  localparam int EXTRA_W            = 13;
  localparam int BITS_W             = 28;
  localparam int COUNT_W            = 5;

  typedef enum logic [2:0] {
    KIND_LOAD_LITLEN = 3'd0,
    KIND_LOAD_DIST   = 3'd1,
    KIND_LITERAL     = 3'd2,
    KIND_LENGTH      = 3'd3,
    KIND_DISTANCE    = 3'd4
  } kind_t;

  typedef struct packed {
    logic                  emit;
    logic                  err;
    logic                  is_dist;
    logic [LIT_SYM_W-1:0]  lit_sym;
    logic [DIST_SYM_W-1:0] dist_sym;
    logic [EXTRA_W-1:0]    extra;
    logic [LEN_W-1:0]      n_extra;
  } map_t;

endpackage

/* design/deflate_huffman_symbol_encoder_unit.sv */
// Top level of the DEFLATE Huffman symbol encoder: table memories and beat pipeline.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  kind, table_index, code_word, code_length,
//                                          symbol_value
//   out_     output     out_valid/out_stall code_bits, code_bit_count, range_error
//   cfg_     input      cfg_we             cfg_wdata (reverse_codes)
//
// One input beat is taken every cycle while in_stall is low; an encode result is registered
// by the synchronous read of the code table memories and then by the output register.
// Load beats write the memory in the cycle they are taken and give no result.
// Reset clears the pipeline and sets reverse_codes; the tables hold nothing until loaded.
// in_stall rises only while both the memory read stage and the output register are full
// and out_stall is high.
module deflate_huffman_symbol_encoder_unit #(
  parameter int LITLEN_SYMBOLS = dhse_pkg::LITLEN_SYMBOLS_DEF,
  parameter int DIST_SYMBOLS   = dhse_pkg::DIST_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [8:0]  in_table_index,
  input  logic [14:0] in_code_word,
  input  logic [3:0]  in_code_length,
  input  logic [15:0] in_symbol_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [27:0] out_code_bits,
  output logic [4:0]  out_code_bit_count,
  output logic        out_range_error
);
  import dhse_pkg::*;

  localparam int LIT_AW  = $clog2(LITLEN_SYMBOLS);
  localparam int DIST_AW = $clog2(DIST_SYMBOLS);
  localparam logic [9:0] LIT_LIMIT  = 10'(LITLEN_SYMBOLS);
  localparam logic [9:0] DIST_LIMIT = 10'(DIST_SYMBOLS);

  logic reverse_r, reverse_nxt;

  map_t map;
  logic accept;
  kind_t in_k;

  logic [MAX_CODE_BITS-1:0] masked_code;
  logic [MAX_CODE_BITS-1:0] rev_code;
  logic [ENTRY_W-1:0]       entry;
  logic                     lit_we;
  logic                     dist_we;
  logic                     lit_re;
  logic                     dist_re;
  logic [ENTRY_W-1:0]       lit_rdata;
  logic [ENTRY_W-1:0]       dist_rdata;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_err_r;
  logic               s1_dist_r;
  logic [EXTRA_W-1:0] s1_extra_r;
  logic [LEN_W-1:0]   s1_nextra_r;
  logic               s1_adv;

  logic [ENTRY_W-1:0]       s1_entry;
  logic [LEN_W-1:0]         s1_len;
  logic [BITS_W-1:0]        s1_bits;
  logic [COUNT_W-1:0]       s1_count;

  logic               out_valid_r, out_valid_nxt;
  logic [BITS_W-1:0]  out_bits_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_err_r;

  dhse_sym_map #(
    .LITLEN_SYMBOLS (LITLEN_SYMBOLS),
    .DIST_SYMBOLS   (DIST_SYMBOLS)
  ) u_map (
    .kind         (in_kind),
    .symbol_value (in_symbol_value),
    .map_o        (map)
  );

  assign in_stall = s1_valid_r & out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign in_k     = kind_t'(in_kind);

  always_comb begin
    masked_code = in_code_word & ((15'd1 << in_code_length) - 15'd1);
    rev_code    = '0;
    for (int j = 0; j < MAX_CODE_BITS; j++) begin
      if (4'(j) < in_code_length) begin
        rev_code[j] = masked_code[in_code_length - 4'(j) - 4'd1];
      end
    end
    entry = {in_code_length, (reverse_r ? rev_code : masked_code)};
  end

  assign lit_we  = accept & (in_k == KIND_LOAD_LITLEN) & ({1'b0, in_table_index} < LIT_LIMIT);
  assign dist_we = accept & (in_k == KIND_LOAD_DIST) & ({1'b0, in_table_index} < DIST_LIMIT);
  assign lit_re  = accept & map.emit & ~map.err & ~map.is_dist;
  assign dist_re = accept & map.emit & ~map.err & map.is_dist;

  dhse_code_mem #(
    .DEPTH (LITLEN_SYMBOLS),
    .AW    (LIT_AW)
  ) u_lit_mem (
    .clk   (clk),
    .we    (lit_we),
    .waddr (in_table_index[LIT_AW-1:0]),
    .wdata (entry),
    .re    (lit_re),
    .raddr (map.lit_sym[LIT_AW-1:0]),
    .rdata (lit_rdata)
  );

  dhse_code_mem #(
    .DEPTH (DIST_SYMBOLS),
    .AW    (DIST_AW)
  ) u_dist_mem (
    .clk   (clk),
    .we    (dist_we),
    .waddr (in_table_index[DIST_AW-1:0]),
    .wdata (entry),
    .re    (dist_re),
    .raddr (map.dist_sym[DIST_AW-1:0]),
    .rdata (dist_rdata)
  );

  assign reverse_nxt = cfg_we ? cfg_wdata : reverse_r;

  assign s1_adv = s1_valid_r & (~out_valid_r | ~out_stall);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept && map.emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    s1_entry = s1_dist_r ? dist_rdata : lit_rdata;
    s1_len   = s1_entry[ENTRY_W-1:MAX_CODE_BITS];
    s1_bits  = {(BITS_W-MAX_CODE_BITS)'(0), s1_entry[MAX_CODE_BITS-1:0]}
             | ({(BITS_W-EXTRA_W)'(0), s1_extra_r} << s1_len);
    s1_count = {1'b0, s1_len} + {1'b0, s1_nextra_r};
    if (s1_err_r) begin
      s1_bits  = '0;
      s1_count = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r   <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      reverse_r   <= reverse_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && map.emit) begin
      s1_err_r    <= map.err;
      s1_dist_r   <= map.is_dist;
      s1_extra_r  <= map.extra;
      s1_nextra_r <= map.n_extra;
    end
    if (s1_adv) begin
      out_bits_r  <= s1_bits;
      out_count_r <= s1_count;
      out_err_r   <= s1_err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_bits      = out_bits_r;
  assign out_code_bit_count = out_count_r;
  assign out_range_error    = out_err_r;

endmodule

/* design/dhse_code_mem.sv */
// Code table memory with one write port and one registered read port.
module dhse_code_mem #(
  parameter int DEPTH = 30,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [dhse_pkg::ENTRY_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [dhse_pkg::ENTRY_W-1:0] rdata
);
  import dhse_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/dhse_sym_map.sv */
// Maps an encode beat to its table symbol, extra bits and range flag.
module dhse_sym_map #(
  parameter int LITLEN_SYMBOLS = dhse_pkg::LITLEN_SYMBOLS_DEF,
  parameter int DIST_SYMBOLS   = dhse_pkg::DIST_SYMBOLS_DEF
) (
  input  logic [2:0]       kind,
  input  logic [15:0]      symbol_value,
  output dhse_pkg::map_t   map_o
);
  import dhse_pkg::*;

  localparam logic [LIT_SYM_W:0]  LIT_LIMIT  = (LIT_SYM_W+1)'(LITLEN_SYMBOLS);
  localparam logic [DIST_SYM_W:0] DIST_LIMIT = (DIST_SYM_W+1)'(DIST_SYMBOLS);

  function automatic logic [3:0] bit_width(input logic [14:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  kind_t       k;
  map_t        m;
  logic [15:0] diff;
  logic [7:0]  lv;
  logic [14:0] dv;
  logic [3:0]  nb;
  logic [3:0]  ne;
  logic [7:0]  lshift;
  logic [14:0] dshift;

  always_comb begin
    k      = kind_t'(kind);
    m      = '0;
    diff   = '0;
    lv     = '0;
    dv     = '0;
    nb     = '0;
    ne     = '0;
    lshift = '0;
    dshift = '0;
    case (k)
      KIND_LITERAL: begin
        m.emit = 1'b1;
        if (symbol_value > 16'd256) begin
          m.err = 1'b1;
        end else begin
          m.lit_sym = symbol_value[LIT_SYM_W-1:0];
        end
      end
      KIND_LENGTH: begin
        m.emit = 1'b1;
        if (symbol_value < 16'd3 || symbol_value > 16'd258) begin
          m.err = 1'b1;
        end else begin
          diff = symbol_value - 16'd3;
          lv   = diff[7:0];
          if (symbol_value == 16'd258) begin
            m.lit_sym = 9'd285;
          end else if (lv < 8'd8) begin
            m.lit_sym = 9'd257 + {1'b0, lv};
          end else begin
            nb        = bit_width({7'd0, lv});
            ne        = nb - 4'd3;
            lshift    = lv >> ne;
            m.n_extra = ne;
            m.extra   = {5'd0, lv & ((8'd1 << ne) - 8'd1)};
            m.lit_sym = 9'd257 + {3'd0, (nb - 4'd2), 2'b00} + {7'd0, lshift[1:0]};
          end
          if ({1'b0, m.lit_sym} >= LIT_LIMIT) begin
            m.err = 1'b1;
          end
        end
      end
      KIND_DISTANCE: begin
        m.emit    = 1'b1;
        m.is_dist = 1'b1;
        if (symbol_value < 16'd1 || symbol_value > 16'd32768) begin
          m.err = 1'b1;
        end else begin
          diff = symbol_value - 16'd1;
          dv   = diff[14:0];
          if (dv < 15'd4) begin
            m.dist_sym = dv[DIST_SYM_W-1:0];
          end else begin
            nb         = bit_width(dv);
            ne         = nb - 4'd2;
            dshift     = dv >> ne;
            m.n_extra  = ne;
            m.extra    = 13'((dv & ((15'd1 << ne) - 15'd1)));
            m.dist_sym = {(nb - 4'd1), 1'b0} + {4'd0, dshift[0]};
          end
          if ({1'b0, m.dist_sym} >= DIST_LIMIT) begin
            m.err = 1'b1;
          end
        end
      end
      default: begin
        m = '0;
      end
    endcase
  end

  assign map_o = m;

endmodule

/* design/dhse_checker.sv */
// Port-level checks of the DEFLATE Huffman symbol encoder, bound to its top level.
`include "assert_macros.svh"

module dhse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [27:0] out_code_bits,
  input logic [4:0]  out_code_bit_count,
  input logic        out_range_error
);

  `ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "out_valid set after reset")

  `ASSERT_CLK(a_stall_holds, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_code_bits) && $stable(out_code_bit_count) && $stable(out_range_error), "stalled result beat changed")

  `ASSERT_CLK(a_error_zero, clk, rst_n, out_valid && out_range_error |-> out_code_bits == 28'd0 && out_code_bit_count == 5'd0, "range error beat carries bits")

  `ASSERT_CLK(a_count_max, clk, rst_n, out_valid |-> out_code_bit_count <= 5'd28, "bit count above 28")

endmodule

bind deflate_huffman_symbol_encoder_unit dhse_checker u_dhse_checker (.*);

/* dv/deflate_huffman_symbol_encoder_unit_test.sv */
// Self-checking testbench of the DEFLATE Huffman symbol encoder unit with its own table predictor.
module deflate_huffman_symbol_encoder_unit_test;
  import dhse_pkg::*;

  localparam int LIT_MAX = 256;
  localparam int LEN_MIN = 3;
  localparam int LEN_MAX = 258;
  localparam int DIST_MIN = 1;
  localparam int DIST_MAX = 32768;
  localparam int LENGTH_SYM_BASE = 257;
  localparam int LENGTH_MAX_SYM = 285;
  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic [BITS_W-1:0]  bits;
    logic [COUNT_W-1:0] count;
    logic               range_err;
  } symbol_code_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [8:0]  in_table_index;
  logic [14:0] in_code_word;
  logic [3:0]  in_code_length;
  logic [15:0] in_symbol_value;
  logic        out_valid;
  logic        out_stall;
  logic [27:0] out_code_bits;
  logic [4:0]  out_code_bit_count;
  logic        out_range_error;

  logic [ENTRY_W-1:0] litlen_table [LITLEN_SYMBOLS_DEF];
  logic [ENTRY_W-1:0] distance_entries [DIST_SYMBOLS_DEF];
  logic               reverse_on_load;
  symbol_code_t       pending_codes [$];
  int                 errors;
  int                 receiver_hold;
  bit                 sender_gaps;

  deflate_huffman_symbol_encoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_table_index     (in_table_index),
    .in_code_word       (in_code_word),
    .in_code_length     (in_code_length),
    .in_symbol_value    (in_symbol_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code_bits      (out_code_bits),
    .out_code_bit_count (out_code_bit_count),
    .out_range_error    (out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 500000);
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned bit_width(int unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic logic [ENTRY_W-1:0] pack_entry(logic [14:0] code, logic [3:0] len);
    int unsigned mask;
    logic [14:0] kept;
    logic [14:0] stored;
    mask = (32'd1 << len) - 32'd1;
    kept = code & mask[14:0];
    stored = kept;
    if (reverse_on_load) begin
      stored = '0;
      for (int i = 0; i < len; i++) stored[len - 1 - i] = kept[i];
    end
    return {len, stored};
  endfunction

  function automatic symbol_code_t encode_symbol(logic [2:0] kind, logic [15:0] val);
    symbol_code_t       r;
    logic [ENTRY_W-1:0] entry;
    int unsigned        v, n, n_extra, extra, sym;
    logic [63:0]        wide;
    r = '0;
    n_extra = 0;
    extra = 0;
    if (kind == KIND_LITERAL) begin
      if (val > LIT_MAX) begin
        r.range_err = 1'b1;
        return r;
      end
      entry = litlen_table[val];
    end else if (kind == KIND_LENGTH) begin
      if (val < LEN_MIN || val > LEN_MAX) begin
        r.range_err = 1'b1;
        return r;
      end
      v = val - LEN_MIN;
      if (val == LEN_MAX) begin
        sym = LENGTH_MAX_SYM;
      end else if (v < 8) begin
        sym = LENGTH_SYM_BASE + v;
      end else begin
        n = bit_width(v);
        n_extra = n - 3;
        extra = v & ((32'd1 << n_extra) - 1);
        sym = LENGTH_SYM_BASE + 4 * (n - 2) + ((v >> n_extra) & 3);
      end
      entry = litlen_table[sym];
    end else begin
      if (val < DIST_MIN || val > DIST_MAX) begin
        r.range_err = 1'b1;
        return r;
      end
      v = val - DIST_MIN;
      if (v < 4) begin
        sym = v;
      end else begin
        n = bit_width(v);
        n_extra = n - 2;
        extra = v & ((32'd1 << n_extra) - 1);
        sym = 2 * (n - 1) + ((v >> n_extra) & 1);
      end
      entry = distance_entries[sym];
    end
    wide = 64'(entry[MAX_CODE_BITS-1:0]) | (64'(extra) << entry[ENTRY_W-1:MAX_CODE_BITS]);
    r.bits = wide[BITS_W-1:0];
    r.count = COUNT_W'(entry[ENTRY_W-1:MAX_CODE_BITS] + n_extra);
    return r;
  endfunction

  task automatic send_item(logic [2:0] kind, logic [8:0] idx, logic [14:0] code,
                           logic [3:0] len, logic [15:0] val);
    int gap;
    if (sender_gaps && $urandom_range(99) < 30) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(24, 6) : $urandom_range(2, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_table_index <= idx;
    in_code_word <= code;
    in_code_length <= len;
    in_symbol_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (kind)
      KIND_LOAD_LITLEN: if (idx < LITLEN_SYMBOLS_DEF) litlen_table[idx] = pack_entry(code, len);
      KIND_LOAD_DIST:   if (idx < DIST_SYMBOLS_DEF) distance_entries[idx] = pack_entry(code, len);
      KIND_LITERAL, KIND_LENGTH, KIND_DISTANCE: pending_codes.push_back(encode_symbol(kind, val));
      default: ;
    endcase
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reverse_codes(logic value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reverse_on_load = value;
  endtask

  task automatic load_tables();
    for (int i = 0; i < LITLEN_SYMBOLS_DEF; i++)
      send_item(KIND_LOAD_LITLEN, 9'(i), 15'($urandom), 4'($urandom), 16'($urandom));
    for (int i = 0; i < DIST_SYMBOLS_DEF; i++)
      send_item(KIND_LOAD_DIST, 9'(i), 15'($urandom), 4'($urandom), 16'($urandom));
  endtask

  task automatic test_directed_edges();
    send_item(KIND_LOAD_LITLEN, 9'd0, 15'h7FFF, 4'd15, 16'd0);
    send_item(KIND_LOAD_LITLEN, 9'd256, 15'h7FF5, 4'd3, 16'd0);
    send_item(KIND_LOAD_LITLEN, 9'd286, 15'h1234, 4'd7, 16'd0);
    send_item(KIND_LOAD_LITLEN, 9'h1FF, 15'h5555, 4'd9, 16'd0);
    send_item(KIND_LOAD_DIST, 9'd30, 15'h2AAA, 4'd5, 16'd0);
    send_item(KIND_LOAD_DIST, 9'd29, 15'h1234, 4'd0, 16'd0);
    send_item(KIND_LITERAL, 9'd0, 15'd0, 4'd0, 16'd0);
    send_item(KIND_LITERAL, 9'd0, 15'd0, 4'd0, 16'd256);
    send_item(KIND_LITERAL, 9'd0, 15'd0, 4'd0, 16'd257);
    send_item(KIND_LITERAL, 9'd0, 15'd0, 4'd0, 16'hFFFF);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd0);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd2);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd3);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd10);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd11);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd257);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd258);
    send_item(KIND_LENGTH, 9'd0, 15'd0, 4'd0, 16'd259);
    send_item(KIND_DISTANCE, 9'd0, 15'd0, 4'd0, 16'd0);
    send_item(KIND_DISTANCE, 9'd0, 15'd0, 4'd0, 16'd1);
    send_item(KIND_DISTANCE, 9'd0, 15'd0, 4'd0, 16'd4);
    send_item(KIND_DISTANCE, 9'd0, 15'd0, 4'd0, 16'd5);
    send_item(KIND_DISTANCE, 9'd0, 15'd0, 4'd0, 16'd32768);
    send_item(KIND_DISTANCE, 9'd0, 15'd0, 4'd0, 16'd32769);
    for (int k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI; k++)
      send_item(3'(k), 9'd0, 15'h7FFF, 4'd15, 16'd5);
  endtask

  task automatic send_random_item();
    logic [2:0]  kind;
    logic [8:0]  idx;
    logic [14:0] code;
    logic [3:0]  len;
    logic [15:0] val;
    int          pick;
    pick = $urandom_range(99);
    idx = 9'($urandom);
    code = 15'($urandom);
    len = 4'($urandom);
    val = 16'($urandom);
    if (pick < 12) begin
      kind = KIND_LOAD_LITLEN;
      if ($urandom_range(15) != 0) idx = 9'($urandom_range(LITLEN_SYMBOLS_DEF - 1));
    end else if (pick < 20) begin
      kind = KIND_LOAD_DIST;
      if ($urandom_range(15) != 0) idx = 9'($urandom_range(DIST_SYMBOLS_DEF - 1));
    end else if (pick < 40) begin
      kind = KIND_LITERAL;
      if ($urandom_range(9) != 0) val = 16'($urandom_range(LIT_MAX));
    end else if (pick < 65) begin
      kind = KIND_LENGTH;
      if ($urandom_range(9) != 0) val = 16'($urandom_range(LEN_MAX, LEN_MIN));
    end else if (pick < 95) begin
      kind = KIND_DISTANCE;
      if ($urandom_range(9) != 0)
        val = 16'(($urandom_range(DIST_MAX - 1) >> $urandom_range(14)) + DIST_MIN);
    end else begin
      kind = 3'($urandom_range(KIND_RESERVED_HI, KIND_RESERVED_LO));
    end
    send_item(kind, idx, code, len, val);
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) sender_gaps = ($urandom_range(3) != 0);
      send_random_item();
    end
    sender_gaps = 1'b1;
  endtask

  // The receiver holds off while beats keep coming, so the pipeline fills and stalls its input.
  task automatic test_receiver_hold();
    wait_until_drained();
    sender_gaps = 1'b0;
    receiver_hold = 80;
    repeat (30)
      send_item(KIND_DISTANCE, 9'($urandom), 15'($urandom), 4'($urandom),
                16'($urandom_range(DIST_MAX, DIST_MIN)));
    sender_gaps = 1'b1;
  endtask

  initial begin : receiver_stall
    int stall_left;
    bit calm;
    stall_left = 0;
    calm = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(249) == 0) calm = !calm;
      if (receiver_hold > 0) begin
        out_stall <= 1'b1;
        receiver_hold--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(99) < 25) begin
        stall_left = ($urandom_range(11) == 0) ? $urandom_range(30, 8) : $urandom_range(2, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_result
    symbol_code_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $error("result beat with nothing expected: code_bits %h", out_code_bits);
        errors++;
      end else begin
        want = pending_codes.pop_front();
        if (out_code_bits !== want.bits) begin
          $error("code_bits: expected %h, actual %h", want.bits, out_code_bits);
          errors++;
        end
        if (out_code_bit_count !== want.count) begin
          $error("code_bit_count: expected %0d, actual %0d", want.count, out_code_bit_count);
          errors++;
        end
        if (out_range_error !== want.range_err) begin
          $error("range_error: expected %b, actual %b", want.range_err, out_range_error);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    receiver_hold = 0;
    sender_gaps = 1'b1;
    reverse_on_load = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_table_index = '0;
    in_code_word = '0;
    in_code_length = '0;
    in_symbol_value = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_reverse_codes(1'b1);
    load_tables();
    test_directed_edges();
    test_random_traffic(30);
    wait_until_drained();
    write_reverse_codes(1'b0);
    test_random_traffic(25);
    test_receiver_hold();
    wait_until_drained();
    write_reverse_codes(1'b1);
    test_random_traffic(25);
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_codes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
